FILE: src/gga_pkg.sv
// ----------------------------------------------------------------------------
// gga_pkg
// Shared types and constants of the GGA position parser: character codes,
// header table, field command passed from the byte scanner to the converter.
// ----------------------------------------------------------------------------
package gga_pkg;

  // Characters
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharN      = 8'h4E;
  localparam logic [7:0] CharE      = 8'h45;
  localparam logic [7:0] CharG      = 8'h47;
  localparam logic [7:0] CharP      = 8'h50;
  localparam logic [7:0] CharA      = 8'h41;

  localparam int HeaderLen = 7;

  // Field widths sized for the widest supported digit counts
  localparam int HiW   = 14;  // integer part / 100, up to 9999
  localparam int LoW   = 7;   // integer part mod 100
  localparam int FracW = 24;  // fraction digits scaled to a fixed count, below 10^7

  localparam logic [31:0] E7        = 32'd10000000;
  localparam logic [30:0] LatLimit  = 31'd900000000;
  localparam logic [30:0] LonLimit  = 31'd1800000000;
  localparam logic [7:0]  HiDegMax  = 8'd180;
  // (2^32 - 1) / 15, exact
  localparam logic [31:0] Recip15   = 32'd286331153;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    SCAN_TIME    = 3'd0,
    SCAN_LAT     = 3'd1,
    SCAN_NS      = 3'd2,
    SCAN_NS_REST = 3'd3,
    SCAN_LON     = 3'd4,
    SCAN_EW      = 3'd5
  } scan_t;

  typedef struct packed {
    logic is_lon;
    logic north;
    logic east;
    logic num_ok;
  } fix_tag_t;

  typedef struct packed {
    fix_tag_t           tag;
    logic [HiW-1:0]     hi;
    logic [LoW-1:0]     lo;
    logic [FracW-1:0]   frac;
  } fix_cmd_t;

  function automatic logic [31:0] pow10(input logic [3:0] n);
    logic [31:0] p;
    case (n)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CharDollar;
      3'd1:    c = CharG;
      3'd2:    c = CharP;
      3'd3:    c = CharG;
      3'd4:    c = CharG;
      3'd5:    c = CharA;
      default: c = CharComma;
    endcase
    return c;
  endfunction

endpackage

FILE: src/gga_if.sv
// ----------------------------------------------------------------------------
// gga_if
// Valid/ready stream interfaces: received characters in, position fixes out.
// ----------------------------------------------------------------------------
interface gga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface gga_fix_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic               coord_valid;

  modport source (output valid, output latitude_e7, output longitude_e7,
                  output coord_valid, input ready);
  modport sink   (input valid, input latitude_e7, input longitude_e7,
                  input coord_valid, output ready);
endinterface

FILE: src/gga_front.sv
// ----------------------------------------------------------------------------
// gga_front
// Byte scanner: hunts the header, tracks the field position and accumulates
// the latitude and longitude numbers. Pushes one command per finished number.
// ----------------------------------------------------------------------------
module gga_front #(
  parameter int FRAC_DIGITS,
  parameter int INT_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  gga_byte_if.sink          chars,
  input  logic              q_full,
  output logic              push,
  output gga_pkg::fix_cmd_t push_data
);
  import gga_pkg::*;

  localparam logic [16:0] HiMax = 17'(pow10(4'(INT_DIGITS - 2)) - 32'd1);

  logic [2:0]       header_match, header_match_next;
  logic             in_sentence, in_sentence_next;
  scan_t            scan, scan_next;
  logic [HiW-1:0]   hi, hi_next;
  logic [LoW-1:0]   lo, lo_next;
  logic [FracW-1:0] frac, frac_next;
  logic [2:0]       frac_count, frac_count_next;
  logic             point_seen, point_seen_next;
  logic             digit_seen, digit_seen_next;
  logic             number_ended, number_ended_next;
  logic             int_overflow, int_overflow_next;
  logic             north_flag, north_flag_next;

  logic [HiW-1:0]   f_hi;
  logic [LoW-1:0]   f_lo;
  logic [FracW-1:0] f_frac;
  logic [2:0]       f_cnt;
  logic             f_point, f_digit, f_ended, f_ovf;

  logic [7:0]  b;
  logic        is_digit;
  logic [3:0]  d;
  logic [9:0]  lo10;
  logic [3:0]  carry;
  logic [16:0] new_hi;
  logic [LoW-1:0]   new_lo;
  logic [FracW-1:0] frac_add;
  logic        accept, do_feed, do_clear;

  assign chars.ready = !q_full;
  assign accept      = chars.valid && chars.ready;
  assign b           = chars.byte_in;
  assign is_digit    = (b >= CharZero) && (b <= CharNine);
  assign d           = 4'(b - CharZero);

  // Number accumulator: integer part kept as (value / 100, value mod 100)
  always_comb begin
    lo10  = 10'(lo) * 10'd10 + 10'(d);
    carry = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (lo10 >= 10'(i * 100)) carry = 4'(i);
    end
    new_hi   = 17'(hi) * 17'd10 + 17'(carry);
    new_lo   = 7'(lo10 - 10'(carry) * 10'd100);
    frac_add = FracW'(24'(d) * 24'(pow10(4'(FRAC_DIGITS - 1) - 4'(frac_count))));

    f_hi    = hi;
    f_lo    = lo;
    f_frac  = frac;
    f_cnt   = frac_count;
    f_point = point_seen;
    f_digit = digit_seen;
    f_ended = number_ended;
    f_ovf   = int_overflow;
    if (!number_ended) begin
      if (is_digit) begin
        if (!point_seen) begin
          if (new_hi > HiMax) begin
            f_ovf = 1'b1;
          end else begin
            f_hi = HiW'(new_hi);
            f_lo = new_lo;
          end
        end else if (frac_count < 3'(FRAC_DIGITS)) begin
          f_frac = frac + frac_add;
          f_cnt  = frac_count + 3'd1;
        end
        f_digit = 1'b1;
      end else if (b == CharDot && !point_seen) begin
        f_point = 1'b1;
      end else begin
        f_ended = 1'b1;
      end
    end
  end

  always_comb begin
    header_match_next = header_match;
    in_sentence_next  = in_sentence;
    scan_next         = scan;
    north_flag_next   = north_flag;
    do_feed           = 1'b0;
    do_clear          = 1'b0;
    push              = 1'b0;
    push_data.tag.is_lon = 1'b0;
    push_data.tag.north  = north_flag;
    push_data.tag.east   = (b == CharE);
    push_data.tag.num_ok = digit_seen && !int_overflow;
    push_data.hi         = hi;
    push_data.lo         = lo;
    push_data.frac       = frac;

    if (accept) begin
      if (!in_sentence) begin
        if (b == header_char(header_match)) begin
          if (header_match == 3'(HeaderLen - 1)) begin
            header_match_next = 3'd0;
            in_sentence_next  = 1'b1;
            scan_next         = SCAN_TIME;
            north_flag_next   = 1'b1;
            do_clear          = 1'b1;
          end else begin
            header_match_next = header_match + 3'd1;
          end
        end else begin
          header_match_next = (b == CharDollar) ? 3'd1 : 3'd0;
        end
      end else begin
        unique case (scan)
          SCAN_TIME: begin
            if (b == CharComma) begin
              scan_next = SCAN_LAT;
              do_clear  = 1'b1;
            end
          end
          SCAN_LAT: begin
            if (b == CharComma) begin
              push      = 1'b1;
              scan_next = SCAN_NS;
            end else begin
              do_feed = 1'b1;
            end
          end
          SCAN_NS: begin
            north_flag_next = (b == CharN);
            if (b == CharComma) begin
              scan_next = SCAN_LON;
              do_clear  = 1'b1;
            end else begin
              scan_next = SCAN_NS_REST;
            end
          end
          SCAN_NS_REST: begin
            if (b == CharComma) begin
              scan_next = SCAN_LON;
              do_clear  = 1'b1;
            end
          end
          SCAN_LON: begin
            if (b == CharComma) scan_next = SCAN_EW;
            else do_feed = 1'b1;
          end
          default: begin
            // hemisphere byte: finish longitude, byte may also open a header
            push                 = 1'b1;
            push_data.tag.is_lon = 1'b1;
            in_sentence_next     = 1'b0;
            scan_next            = SCAN_TIME;
            header_match_next    = (b == CharDollar) ? 3'd1 : 3'd0;
          end
        endcase
      end
    end

    hi_next           = hi;
    lo_next           = lo;
    frac_next         = frac;
    frac_count_next   = frac_count;
    point_seen_next   = point_seen;
    digit_seen_next   = digit_seen;
    number_ended_next = number_ended;
    int_overflow_next = int_overflow;
    if (do_clear) begin
      hi_next           = '0;
      lo_next           = '0;
      frac_next         = '0;
      frac_count_next   = '0;
      point_seen_next   = 1'b0;
      digit_seen_next   = 1'b0;
      number_ended_next = 1'b0;
      int_overflow_next = 1'b0;
    end else if (do_feed) begin
      hi_next           = f_hi;
      lo_next           = f_lo;
      frac_next         = f_frac;
      frac_count_next   = f_cnt;
      point_seen_next   = f_point;
      digit_seen_next   = f_digit;
      number_ended_next = f_ended;
      int_overflow_next = f_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_match <= 3'd0;
      in_sentence  <= 1'b0;
      scan         <= SCAN_TIME;
    end else begin
      header_match <= header_match_next;
      in_sentence  <= in_sentence_next;
      scan         <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    hi           <= hi_next;
    lo           <= lo_next;
    frac         <= frac_next;
    frac_count   <= frac_count_next;
    point_seen   <= point_seen_next;
    digit_seen   <= digit_seen_next;
    number_ended <= number_ended_next;
    int_overflow <= int_overflow_next;
    north_flag   <= north_flag_next;
  end

endmodule

FILE: src/gga_queue.sv
// ----------------------------------------------------------------------------
// gga_queue
// Short FIFO of finished field commands between scanner and converter.
// ----------------------------------------------------------------------------
module gga_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gga_pkg::fix_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output gga_pkg::fix_cmd_t pop_data
);
  import gga_pkg::*;

  fix_cmd_t         mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;

  assign full      = (count == (QPtrW + 1)'(QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPtrW + 1)'(push) - (QPtrW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

FILE: src/gga_back.sv
// ----------------------------------------------------------------------------
// gga_back
// Converter: three-stage pipeline turning ddmm.mmmm fields into degrees * 1e7,
// range check, latitude hold and the registered fix output.
// ----------------------------------------------------------------------------
module gga_back #(
  parameter int FRAC_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  gga_pkg::fix_cmd_t q_data,
  output logic              q_pop,
  gga_fix_if.source         fix
);
  import gga_pkg::*;

  localparam logic [29:0] FracScale = 30'(pow10(4'(7 - FRAC_DIGITS)));

  // stage 1: minutes scaled to 1e7 / 60 units
  logic        s1_v;
  fix_tag_t    s1_tag;
  logic [29:0] s1_y;
  logic [7:0]  s1_hi;
  logic        s1_hi_big;
  // stage 2: quotient estimate
  logic        s2_v;
  fix_tag_t    s2_tag;
  logic [29:0] s2_y;
  logic [24:0] s2_q0;
  logic [30:0] s2_hm;
  logic        s2_hi_big;
  // stage 3: magnitude
  logic        s3_v;
  fix_tag_t    s3_tag;
  logic [30:0] s3_m;
  logic        s3_rem_zero;
  logic        s3_hi_big;

  logic [29:0] lat_mag;
  logic        lat_ok;

  logic        retire, s3_free, s2_move, s2_free, s1_move, s1_free;
  logic [29:0] y_in;
  logic        hi_big_in;
  logic [56:0] prod;
  logic [29:0] r0;
  logic        q_fix;
  logic [24:0] q;
  logic [30:0] lim, m_next;
  logic        ok, valid_out;

  assign retire  = s3_v && (!s3_tag.is_lon || !fix.valid || fix.ready);
  assign s3_free = !s3_v || retire;
  assign s2_move = s2_v && s3_free;
  assign s2_free = !s2_v || s2_move;
  assign s1_move = s1_v && s2_free;
  assign s1_free = !s1_v || s1_move;
  assign q_pop   = q_valid && s1_free;

  assign y_in      = 30'(q_data.lo) * 30'(E7) + 30'(q_data.frac) * FracScale;
  assign hi_big_in = q_data.hi > HiW'(HiDegMax);

  // y / 60 = (y / 4) / 15, reciprocal low by at most one
  assign prod = 57'(s1_y[29:2]) * 57'(Recip15);

  always_comb begin
    r0     = s2_y - 30'(31'(s2_q0) * 31'd60);
    q_fix  = (r0 >= 30'd60);
    q      = s2_q0 + 25'(q_fix);
    m_next = s2_hm + 31'(q);
  end

  always_comb begin
    lim       = s3_tag.is_lon ? LonLimit : LatLimit;
    ok        = s3_tag.num_ok && !s3_hi_big &&
                ((s3_m < lim) || ((s3_m == lim) && s3_rem_zero));
    valid_out = lat_ok && ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      fix.valid <= 1'b0;
    end else begin
      if (q_pop) s1_v <= 1'b1;
      else if (s1_move) s1_v <= 1'b0;
      if (s1_move) s2_v <= 1'b1;
      else if (s2_move) s2_v <= 1'b0;
      if (s2_move) s3_v <= 1'b1;
      else if (retire) s3_v <= 1'b0;
      if (retire && s3_tag.is_lon) fix.valid <= 1'b1;
      else if (fix.ready) fix.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_tag    <= q_data.tag;
      s1_y      <= y_in;
      s1_hi     <= q_data.hi[7:0];
      s1_hi_big <= hi_big_in;
    end
    if (s1_move) begin
      s2_tag    <= s1_tag;
      s2_y      <= s1_y;
      s2_q0     <= prod[56:32];
      s2_hm     <= s1_hi_big ? 31'd0 : 31'(s1_hi) * 31'(E7);
      s2_hi_big <= s1_hi_big;
    end
    if (s2_move) begin
      s3_tag      <= s2_tag;
      s3_m        <= m_next;
      s3_rem_zero <= q_fix ? (r0 == 30'd60) : (r0 == 30'd0);
      s3_hi_big   <= s2_hi_big;
    end
    if (retire) begin
      if (!s3_tag.is_lon) begin
        // hold latitude until its longitude arrives
        lat_mag <= ok ? s3_m[29:0] : 30'd0;
        lat_ok  <= ok;
      end else begin
        fix.coord_valid <= valid_out;
        if (!valid_out) begin
          fix.latitude_e7  <= '0;
          fix.longitude_e7 <= '0;
        end else begin
          fix.latitude_e7  <= s3_tag.north ? $signed(31'(lat_mag))
                                           : -$signed(31'(lat_mag));
          fix.longitude_e7 <= (fix.ready || !fix.valid) && s3_tag.east
                              ? $signed({1'b0, s3_m}) : -$signed({1'b0, s3_m});
        end
      end
    end
  end

endmodule

FILE: src/nmea_gga_position_parser.sv
// ----------------------------------------------------------------------------
// nmea_gga_position_parser
// GGA sentence position extractor: bytes in, latitude/longitude fixes out.
// ----------------------------------------------------------------------------
// Takes one character per cycle on chars and never stalls it unless four
// finished fields are still waiting in the queue between the scanner and the
// converter. A fix leaves on fix once the east/west byte's command has passed
// the queue, the three converter stages and the output register; the rate of one
// byte per cycle is set by the scanner, which handles every byte in one step.
// Output backpressure fills the converter pipeline and then the queue before
// chars is held off.
module nmea_gga_position_parser #(
  parameter int FRAC_DIGITS = 5,
  parameter int INT_DIGITS  = 5
) (
  input  logic      clk,
  input  logic      rst,
  gga_byte_if.sink  chars,
  gga_fix_if.source fix
);
  import gga_pkg::*;

  logic     q_full, push, q_pop, q_valid;
  fix_cmd_t push_data, q_data;

  gga_front #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .INT_DIGITS  (INT_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  gga_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  gga_back #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .fix     (fix)
  );

  // a finished field never lands on a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("field command pushed into full queue");

  // an invalid fix carries zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    (fix.valid && !fix.coord_valid) |->
      (fix.latitude_e7 == 31'sd0 && fix.longitude_e7 == 32'sd0))
    else $error("invalid fix with nonzero coordinates");

  // a valid fix stays within the latitude range
  assert property (@(posedge clk) disable iff (rst)
    (fix.valid && fix.coord_valid) |->
      (fix.latitude_e7 <= 31'sd900000000 && fix.latitude_e7 >= -31'sd900000000))
    else $error("latitude out of range on a valid fix");

endmodule
